>>> rtl/ac3_pkg.sv
package ac3_pkg;

    // Bin space and exponent limits
    localparam int BIN_W    = 8;
    localparam int MAX_BINS = 256;
    localparam int EXP_W    = 5;

    localparam logic [EXP_W-1:0] EXP_MAX   = 5'd24;
    localparam logic [6:0]       CODE_MAX  = 7'd124;
    localparam logic [5:0]       DIFF_BIAS = 6'd2;

    // Request kinds
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_GROUP = 1'b1;

    // Exponent strategies
    localparam logic [1:0] MODE_D15 = 2'd1;
    localparam logic [1:0] MODE_D25 = 2'd2;
    localparam logic [1:0] MODE_D45 = 2'd3;

    // Configuration register indexes
    localparam logic CFG_GROUP_MODE = 1'b0;
    localparam logic CFG_END_BINS   = 1'b1;

    localparam logic [1:0] GROUP_MODE_RST = MODE_D15;
    localparam logic [7:0] END_BINS_RST   = 8'd253;

    typedef struct packed {
        logic       func;
        logic [3:0] abs_exponent;
        logic [6:0] group_code;
    } in_item_t;

    typedef struct packed {
        logic [BIN_W-1:0] bin_index;
        logic [EXP_W-1:0] exponent;
        logic             range_error;
        logic             last;
        logic             block_done;
    } out_item_t;

    // Three base-5 digits, most significant first in index 0
    typedef logic [2:0][2:0] digits_t;

    // Classified request as held in the queue
    typedef struct packed {
        logic       func;
        logic [3:0] abs_exponent;
        digits_t    digits;
        logic       code_err;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Split a 7-bit group code into code/25, (code%25)/5, code%5
    function automatic digits_t split_code(input logic [6:0] code);
        logic [2:0] d0;
        logic [2:0] d1;
        logic [6:0] rem25;
        logic [4:0] rem5;
        digits_t    res;
        if (code >= 7'd125)      begin d0 = 3'd5; rem25 = code - 7'd125; end
        else if (code >= 7'd100) begin d0 = 3'd4; rem25 = code - 7'd100; end
        else if (code >= 7'd75)  begin d0 = 3'd3; rem25 = code - 7'd75;  end
        else if (code >= 7'd50)  begin d0 = 3'd2; rem25 = code - 7'd50;  end
        else if (code >= 7'd25)  begin d0 = 3'd1; rem25 = code - 7'd25;  end
        else                     begin d0 = 3'd0; rem25 = code;          end
        rem5 = rem25[4:0];
        if (rem5 >= 5'd20)      d1 = 3'd4;
        else if (rem5 >= 5'd15) d1 = 3'd3;
        else if (rem5 >= 5'd10) d1 = 3'd2;
        else if (rem5 >= 5'd5)  d1 = 3'd1;
        else                    d1 = 3'd0;
        res[0] = d0;
        res[1] = d1;
        res[2] = 3'(rem5 - {d1, 2'b00} - {2'b00, d1});
        return res;
    endfunction

endpackage

>>> rtl/ac3_front.sv
module ac3_front
    import ac3_pkg::*;
(
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    input  q_status_t q_status,
    output logic      q_push,
    output q_entry_t  q_wdata
);

    // Accept whenever the queue has room
    assign in_ready = !q_status.full;
    assign q_push   = in_valid && in_ready;

    // Classify: split the group code and flag illegal codes
    always_comb
    begin
        q_wdata.func         = in_data.func;
        q_wdata.abs_exponent = in_data.abs_exponent;
        q_wdata.digits       = split_code(in_data.group_code);
        q_wdata.code_err     = (in_data.func == FUNC_GROUP) && (in_data.group_code > CODE_MAX);
    end

endmodule

>>> rtl/ac3_queue.sv
module ac3_queue
    import ac3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  wdata,
    input  logic      pop,
    output q_entry_t  rdata,
    output q_status_t status
);

    // Two-entry queue between classifier and sequencer
    q_entry_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign rdata        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = 2'(count_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/ac3_back.sv
module ac3_back
    import ac3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] group_mode,
    input  logic [7:0] end_bins,
    input  q_status_t  q_status,
    input  q_entry_t   q_rdata,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;
    logic [EXP_W-1:0] run_exp_reg, run_exp_next;
    logic             run_err_reg, run_err_next;
    logic [BIN_W-1:0] next_bin_reg, next_bin_next;
    logic [1:0]       dig_reg, dig_next;
    logic [1:0]       rep_reg, rep_next;

    logic             adv;
    logic             step;
    logic             final_step;
    logic [1:0]       rep_max;
    logic [2:0]       digit;
    logic [5:0]       sum;
    logic [EXP_W-1:0] new_exp;
    logic             new_err;
    logic [EXP_W-1:0] cur_exp;
    logic             cur_err;
    logic [BIN_W-1:0] cur_bin;
    logic             emit;

    // Output slot free or being drained
    assign adv  = !out_valid_reg || out_ready;
    assign step = !q_status.empty && adv;

    // Repeat count per exponent from the strategy
    always_comb
    begin
        unique case (group_mode)
            MODE_D25: rep_max = 2'd1;
            MODE_D45: rep_max = 2'd3;
            default:  rep_max = 2'd0;
        endcase
    end

    // Differential add with clamp to 0..EXP_MAX
    always_comb
    begin
        digit   = q_rdata.digits[dig_reg];
        sum     = {1'b0, run_exp_reg} + {3'b000, digit};
        new_err = q_rdata.code_err;
        if (sum < DIFF_BIAS)
        begin
            new_exp = '0;
            new_err = 1'b1;
        end
        else if ((sum - DIFF_BIAS) > {1'b0, EXP_MAX})
        begin
            new_exp = EXP_MAX;
            new_err = 1'b1;
        end
        else
        begin
            new_exp = 5'(sum - DIFF_BIAS);
        end
    end

    // Current bin candidate
    always_comb
    begin
        if (q_rdata.func == FUNC_START)
        begin
            cur_exp    = {1'b0, q_rdata.abs_exponent};
            cur_err    = 1'b0;
            cur_bin    = '0;
            final_step = 1'b1;
        end
        else
        begin
            cur_exp    = (rep_reg == 2'd0) ? new_exp : run_exp_reg;
            cur_err    = (rep_reg == 2'd0) ? new_err : run_err_reg;
            cur_bin    = next_bin_reg;
            final_step = (dig_reg == 2'd2) && (rep_reg == rep_max);
        end
        emit = (cur_bin < end_bins) && ({1'b0, cur_bin} < 9'(MAX_BINS));
    end

    assign q_pop = step && final_step;

    // Sequencer and output register updates
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        run_exp_next   = run_exp_reg;
        run_err_next   = run_err_reg;
        next_bin_next  = next_bin_reg;
        dig_next       = dig_reg;
        rep_next       = rep_reg;
        if (adv)
        begin
            out_valid_next = 1'b0;
        end
        if (step)
        begin
            out_valid_next           = emit;
            out_data_next.bin_index  = cur_bin;
            out_data_next.exponent   = cur_exp;
            out_data_next.range_error = cur_err;
            out_data_next.block_done = (cur_bin == 8'(end_bins - 8'd1));
            out_data_next.last       = final_step || (cur_bin == 8'(end_bins - 8'd1));
            run_exp_next             = cur_exp;
            run_err_next             = cur_err;
            if (q_rdata.func == FUNC_START)
            begin
                next_bin_next = 8'd1;
            end
            else if (next_bin_reg != 8'hFF)
            begin
                next_bin_next = 8'(next_bin_reg + 8'd1);
            end
            if (final_step)
            begin
                dig_next = 2'd0;
                rep_next = 2'd0;
            end
            else if (rep_reg == rep_max)
            begin
                dig_next = 2'(dig_reg + 2'd1);
                rep_next = 2'd0;
            end
            else
            begin
                rep_next = 2'(rep_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            run_exp_reg   <= '0;
            run_err_reg   <= 1'b0;
            next_bin_reg  <= '0;
            dig_reg       <= 2'd0;
            rep_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            run_exp_reg   <= run_exp_next;
            run_err_reg   <= run_err_next;
            next_bin_reg  <= next_bin_next;
            dig_reg       <= dig_next;
            rep_reg       <= rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/ac3_exponent_decoder.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     in_data (func, abs_exponent, group_code)
// out       output     out_valid / out_ready   out_data (bin_index, exponent, flags)
// cfg       input      cfg_write               cfg_index, cfg_data
//
// The sequencer walks one bin per cycle while the output is not stalled: a
// start request covers one bin, a group request 3 x group size bins (3, 6 or
// 12); dropped bins still take their step. The sequencer's single bin slot
// per cycle sets the rate. Reset clears the queue, sequencer and running
// state; registers go to D15 and 253 bins. A two-entry queue lets input
// requests land while the output register is stalled.
module ac3_exponent_decoder
    import ac3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    logic [1:0] group_mode_reg, group_mode_next;
    logic [7:0] end_bins_reg, end_bins_next;
    q_status_t  q_status;
    logic       q_push;
    logic       q_pop;
    q_entry_t   q_wdata;
    q_entry_t   q_rdata;

    // Configuration registers
    always_comb
    begin
        group_mode_next = group_mode_reg;
        end_bins_next   = end_bins_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_GROUP_MODE: group_mode_next = cfg_data[1:0];
                CFG_END_BINS:   end_bins_next   = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_mode_reg <= GROUP_MODE_RST;
            end_bins_reg   <= END_BINS_RST;
        end
        else
        begin
            group_mode_reg <= group_mode_next;
            end_bins_reg   <= end_bins_next;
        end
    end

    ac3_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_status (q_status),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    ac3_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    ac3_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .group_mode (group_mode_reg),
        .end_bins   (end_bins_reg),
        .q_status   (q_status),
        .q_rdata    (q_rdata),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // An accepted request is queued on the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !q_status.empty)
        else $error("accepted request missing from queue");

    // The final bin of the block is always flagged last
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.block_done |-> out_data.last)
        else $error("block_done without last");

    // Only bins inside the configured range are delivered
    a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.bin_index < end_bins_reg)
        else $error("bin past end_bins delivered");

endmodule
